FILE: rtl/core/assert_macros.svh
// assertion macros shared by the ring buffer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising clock, off while reset is active
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent check that also runs during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/urb_pkg.sv
// shared types and constants of the uart ring buffer block
package urb_pkg;

  localparam int unsigned RING_SIZE_DEF = 256;
  localparam logic [7:0]  RTS_LEVEL_RST = 8'd251;

  // item kinds carried in the input tuser
  typedef enum logic [2:0] {
    MODE_HOST_WRITE = 3'd0,
    MODE_HOST_READ  = 3'd1,
    MODE_LINE_RX    = 3'd2,
    MODE_TX_READY   = 3'd3,
    MODE_FLUSH      = 3'd4
  } mode_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture the accepted item and read both rings
    logic exec;  // apply the item and register its result
  } cmd_t;

endpackage

FILE: rtl/core/uart_ring_buffers_with_flow_control_top.sv
// top level of the uart receive and transmit byte rings with rts/cts flow control
//
// usage: every input item on the slave stream is one operation: host write, host
// read, line byte received, transmitter ready or flush, selected by tuser. every
// accepted item gives exactly one result item on the master stream carrying ok,
// the byte read or to transmit, both ring fill counts and the rts level.
// sequence: the ring memories are read with a registered port in the accept cycle;
// in the execute state that follows, the item is applied and its result registered.
// pacing: a new item is taken only after the previous one has been executed, as set by
// the accept/execute sequence of the controller around the single registered read
// of each ring memory.
// reset: all ring pointers go to zero (both rings empty), rts_level returns to
// 251 and no result is pending; ring contents are not cleared. stall: a result
// waits in the output register while m_axis_tready_i is low; a new item is taken
// only once that register is free or is being taken. the user must write rts_level
// through cfg_we_i / cfg_wdata_i only while idle; the block does not enforce it.
module uart_ring_buffers_with_flow_control_top
  import urb_pkg::*;
#(
  parameter int unsigned RING_SIZE = RING_SIZE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // data_in[7:0], cts[8], zero[15:9]
  input  logic [2:0]  s_axis_tuser_i,   // mode[2:0]
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // data_out[7:0], rx_fill[15:8], tx_fill[23:16],
                                        // rts[24], zero[31:25]
  output logic        m_axis_tuser_o,   // ok
  // rts level register
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  cmd_t       cmd;
  logic       ok;
  logic [7:0] data_out, rx_fill, tx_fill;
  logic       rts;

  // handshake sequencing
  urb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  // rings, pointers and result register
  urb_datapath #(
    .RING_SIZE (RING_SIZE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .mode_i      (s_axis_tuser_i),
    .data_in_i   (s_axis_tdata_i[7:0]),
    .cts_i       (s_axis_tdata_i[8]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ok_o        (ok),
    .data_out_o  (data_out),
    .rx_fill_o   (rx_fill),
    .tx_fill_o   (tx_fill),
    .rts_o       (rts)
  );

  // result packing, highest field first
  assign m_axis_tdata_o = {7'd0, rts, tx_fill, rx_fill, data_out};
  assign m_axis_tuser_o = ok;

endmodule

FILE: rtl/core/urb_datapath.sv
// ring storage, pointers, rts level register and result register
`include "assert_macros.svh"

module urb_datapath
  import urb_pkg::*;
#(
  parameter int unsigned RING_SIZE = RING_SIZE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic [2:0] mode_i,
  input  logic [7:0] data_in_i,
  input  logic       cts_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  output logic       ok_o,
  output logic [7:0] data_out_o,
  output logic [7:0] rx_fill_o,
  output logic [7:0] tx_fill_o,
  output logic       rts_o
);

  localparam int unsigned PTR_W = $clog2(RING_SIZE);
  localparam int unsigned EXT_W = (PTR_W > 8) ? PTR_W : 8;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_SIZE - 1);

  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] fill_of(input logic [PTR_W-1:0] head,
                                               input logic [PTR_W-1:0] tail);
    return (head >= tail) ? head - tail : head - tail + PTR_W'(RING_SIZE);
  endfunction

  logic [7:0] rx_mem [RING_SIZE];
  logic [7:0] tx_mem [RING_SIZE];

  logic [PTR_W-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [PTR_W-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [7:0]       rts_level_q;

  logic [2:0] mode_q;
  logic [7:0] data_q;
  logic       cts_q;
  logic [7:0] rx_rd_q, tx_rd_q;

  logic       ok_d, ok_q;
  logic [7:0] dout_d, dout_q;
  logic [7:0] rx_fill_q, tx_fill_q;
  logic       rts_q;
  logic       tx_wr, rx_wr;

  logic [EXT_W-1:0] rx_fill_e, tx_fill_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rts_level_q <= RTS_LEVEL_RST;
    end else if (cfg_we_i) begin
      rts_level_q <= cfg_wdata_i;
    end
  end

  // item capture and registered ring reads at accept time
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      data_q  <= data_in_i;
      cts_q   <= cts_i;
      rx_rd_q <= rx_mem[rx_tail_q];
      tx_rd_q <= tx_mem[tx_tail_q];
    end
  end

  always_comb begin
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    ok_d      = 1'b0;
    dout_d    = 8'd0;
    tx_wr     = 1'b0;
    rx_wr     = 1'b0;
    unique case (mode_q)
      MODE_HOST_WRITE: begin
        if (wrap_next(tx_head_q) != tx_tail_q) begin
          tx_wr     = 1'b1;
          tx_head_d = wrap_next(tx_head_q);
          ok_d      = 1'b1;
        end
      end
      MODE_HOST_READ: begin
        if (rx_head_q != rx_tail_q) begin
          dout_d    = rx_rd_q;
          rx_tail_d = wrap_next(rx_tail_q);
          ok_d      = 1'b1;
        end
      end
      MODE_LINE_RX: begin
        if (wrap_next(rx_head_q) != rx_tail_q) begin
          rx_wr     = 1'b1;
          rx_head_d = wrap_next(rx_head_q);
          ok_d      = 1'b1;
        end
      end
      MODE_TX_READY: begin
        if (!cts_q && (tx_head_q != tx_tail_q)) begin
          dout_d    = tx_rd_q;
          tx_tail_d = wrap_next(tx_tail_q);
          ok_d      = 1'b1;
        end
      end
      MODE_FLUSH: begin
        rx_head_d = '0;
        rx_tail_d = '0;
        tx_head_d = '0;
        tx_tail_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign rx_fill_e = EXT_W'(fill_of(rx_head_d, rx_tail_d));
  assign tx_fill_e = EXT_W'(fill_of(tx_head_d, tx_tail_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q <= '0;
      rx_tail_q <= '0;
      tx_head_q <= '0;
      tx_tail_q <= '0;
    end else if (cmd_i.exec) begin
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && tx_wr) begin
      tx_mem[tx_head_q] <= data_q;
    end
    if (cmd_i.exec && rx_wr) begin
      rx_mem[rx_head_q] <= data_q;
    end
  end

  // result register, counts saturate at one byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      ok_q      <= ok_d;
      dout_q    <= dout_d;
      rx_fill_q <= (rx_fill_e > EXT_W'(255)) ? 8'hff : rx_fill_e[7:0];
      tx_fill_q <= (tx_fill_e > EXT_W'(255)) ? 8'hff : tx_fill_e[7:0];
      rts_q     <= rx_fill_e > EXT_W'(rts_level_q);
    end
  end

  assign ok_o       = ok_q;
  assign data_out_o = dout_q;
  assign rx_fill_o  = rx_fill_q;
  assign tx_fill_o  = tx_fill_q;
  assign rts_o      = rts_q;

  `ASSERT_CLK(a_rx_ptr_range, clk_i, rst_ni,
              (rx_head_q <= LAST_PTR) && (rx_tail_q <= LAST_PTR), "rx pointer out of range")
  `ASSERT_CLK(a_tx_ptr_range, clk_i, rst_ni,
              (tx_head_q <= LAST_PTR) && (tx_tail_q <= LAST_PTR), "tx pointer out of range")
  `ASSERT_CLK(a_flush_clears, clk_i, rst_ni,
              cmd_i.exec && (mode_q == MODE_FLUSH) |=>
              (rx_head_q == '0) && (rx_tail_q == '0) && (tx_head_q == '0) && (tx_tail_q == '0),
              "flush left a pointer set")

endmodule

FILE: rtl/core/urb_ctrl.sv
// handshake controller: accept, execute and output valid tracking
`include "assert_macros.svh"

module urb_ctrl
  import urb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // a new item may enter once the result slot is free or frees this cycle
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign cmd_o.load = in_valid_i && in_ready_o;
  assign cmd_o.exec = (state_q == S_EXEC);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.load) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_CLK(a_load_to_exec, clk_i, rst_ni,
              cmd_o.load |=> cmd_o.exec, "accepted item not executed next cycle")
  `ASSERT_CLK(a_exec_sets_valid, clk_i, rst_ni,
              cmd_o.exec |=> out_valid_q, "executed item produced no result")
  `ASSERT_CLK(a_no_overwrite, clk_i, rst_ni,
              cmd_o.exec |-> !out_valid_q, "result register overwritten before taken")

endmodule
